### design/tta_pkg.sv
package tta_pkg;

    localparam int VERTEX_COUNT = 4096;
    localparam int IDX_W = 12;
    localparam int ADDR_W = 12;
    localparam int SUM_W = 40;
    localparam int CRD_W = 32;
    // deltas 33 bits, products 66 bits, numerator/determinant 67 bits
    localparam int DLT_W = 33;
    localparam int PRD_W = 66;
    localparam int NUM_W = 67;
    // dividend is |num| << 16
    localparam int DVD_W = 82;
    localparam int QUO_W = 41;
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [QUO_W-1:0] Q_CLAMP = {1'b1, {(QUO_W-1){1'b0}}};
    localparam int QFIFO_DEPTH = 2;

    // one triangle handed from the front end to the back end
    typedef struct packed {
        logic [IDX_W-1:0]        idx0;
        logic [IDX_W-1:0]        idx1;
        logic [IDX_W-1:0]        idx2;
        logic signed [DLT_W-1:0] e0x;
        logic signed [DLT_W-1:0] e0y;
        logic signed [DLT_W-1:0] e0z;
        logic signed [DLT_W-1:0] e1x;
        logic signed [DLT_W-1:0] e1y;
        logic signed [DLT_W-1:0] e1z;
        logic signed [DLT_W-1:0] du0;
        logic signed [DLT_W-1:0] du1;
        logic signed [DLT_W-1:0] dv0;
        logic signed [DLT_W-1:0] dv1;
    } tri_t;

    function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] s,
                                                 logic signed [QUO_W:0] q);
        logic signed [SUM_W+1:0] t;
        begin
            t = $signed({{2{s[SUM_W-1]}}, s}) + q;
            if (t > $signed({2'b00, SUM_MAX}))
                sat_add = SUM_MAX;
            else if (t < $signed({2'b11, SUM_MIN}))
                sat_add = SUM_MIN;
            else
                sat_add = t[SUM_W-1:0];
        end
    endfunction

endpackage

### design/tta_front.sv
module tta_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tta_pkg::IDX_W-1:0]      vertex_index,
    input  logic signed [tta_pkg::CRD_W-1:0] pos_x,
    input  logic signed [tta_pkg::CRD_W-1:0] pos_y,
    input  logic signed [tta_pkg::CRD_W-1:0] pos_z,
    input  logic signed [tta_pkg::CRD_W-1:0] tex_u,
    input  logic signed [tta_pkg::CRD_W-1:0] tex_v,
    output logic                           q_valid,
    input  logic                           q_ready,
    output tta_pkg::tri_t                  q_data
);
    import tta_pkg::*;

    logic [1:0]              cnt_reg, cnt_next;
    logic [IDX_W-1:0]        idx_reg [2];
    logic signed [CRD_W-1:0] px_reg [2], py_reg [2], pz_reg [2], u_reg [2], v_reg [2];
    logic                    acc;

    // third corner needs queue space; first two are always taken
    assign in_ready = (cnt_reg != 2'd2) || q_ready;
    assign acc = in_valid && in_ready;
    assign q_valid = in_valid && (cnt_reg == 2'd2);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (acc)
            cnt_next = (cnt_reg == 2'd2) ? 2'd0 : cnt_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (acc && cnt_reg != 2'd2)
        begin
            idx_reg[cnt_reg[0]] <= vertex_index;
            px_reg[cnt_reg[0]]  <= pos_x;
            py_reg[cnt_reg[0]]  <= pos_y;
            pz_reg[cnt_reg[0]]  <= pos_z;
            u_reg[cnt_reg[0]]   <= tex_u;
            v_reg[cnt_reg[0]]   <= tex_v;
        end
    end

    // edge and UV deltas of the triangle
    always_comb
    begin
        q_data.idx0 = idx_reg[0];
        q_data.idx1 = idx_reg[1];
        q_data.idx2 = vertex_index;
        q_data.e0x = DLT_W'(px_reg[1]) - DLT_W'(px_reg[0]);
        q_data.e0y = DLT_W'(py_reg[1]) - DLT_W'(py_reg[0]);
        q_data.e0z = DLT_W'(pz_reg[1]) - DLT_W'(pz_reg[0]);
        q_data.e1x = DLT_W'(pos_x) - DLT_W'(px_reg[0]);
        q_data.e1y = DLT_W'(pos_y) - DLT_W'(py_reg[0]);
        q_data.e1z = DLT_W'(pos_z) - DLT_W'(pz_reg[0]);
        q_data.du0 = DLT_W'(u_reg[1]) - DLT_W'(u_reg[0]);
        q_data.du1 = DLT_W'(tex_u) - DLT_W'(u_reg[0]);
        q_data.dv0 = DLT_W'(v_reg[1]) - DLT_W'(v_reg[0]);
        q_data.dv1 = DLT_W'(tex_v) - DLT_W'(v_reg[0]);
    end

endmodule

### design/tta_queue.sv
module tta_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  tta_pkg::tri_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output tta_pkg::tri_t rd_data
);
    import tta_pkg::*;

    tri_t       mem_reg [QFIFO_DEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign wr_ready = cnt_reg != 2'(QFIFO_DEPTH);
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_valid && wr_ready)
                wp_reg <= ~wp_reg;
            if (rd_valid && rd_ready)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_ready)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

### design/tta_back.sv
module tta_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    output logic                             q_ready,
    input  tta_pkg::tri_t                    q_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tta_pkg::IDX_W-1:0]        out_vertex,
    output logic signed [tta_pkg::SUM_W-1:0] sum_x,
    output logic signed [tta_pkg::SUM_W-1:0] sum_y,
    output logic signed [tta_pkg::SUM_W-1:0] sum_z,
    output logic                             degenerate,
    output logic                             last_of_triangle
);
    import tta_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_SUB  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_RD   = 4'd5;
    localparam logic [3:0] S_WAIT = 4'd6;
    localparam logic [3:0] S_WR   = 4'd7;
    localparam logic [3:0] S_ORD  = 4'd8;
    localparam logic [3:0] S_OWT  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0]  st_reg;
    logic [ADDR_W:0] clr_reg;
    tri_t        t_reg;
    logic [1:0]  k_reg;    // corner
    logic [1:0]  c_reg;    // component
    logic [6:0]  bit_reg;
    logic        degen_reg;

    logic signed [PRD_W-1:0] pa_reg, pb_reg, da_reg, db_reg;
    logic [NUM_W-1:0]        dmag_reg;
    logic [DVD_W-1:0]        dvd_reg;
    logic [NUM_W:0]          rem_reg;
    logic [QUO_W:0]          quo_reg;   // one extra bit flags overflow
    logic                    qneg_reg, dneg_reg;
    logic signed [QUO_W:0]   dir_reg [3];

    // tangent store: one word holds all three sums
    logic [3*SUM_W-1:0] mem [VERTEX_COUNT];
    logic [3*SUM_W-1:0] rd_reg;
    logic [ADDR_W-1:0]  addr;
    logic               inr;
    logic [IDX_W-1:0]   cur_idx;

    assign q_ready = (st_reg == S_IDLE);

    always_comb
    begin
        case (k_reg)
            2'd0:    cur_idx = t_reg.idx0;
            2'd1:    cur_idx = t_reg.idx1;
            default: cur_idx = t_reg.idx2;
        endcase
    end
    assign inr  = 32'(cur_idx) < VERTEX_COUNT;
    assign addr = ADDR_W'(cur_idx);

    logic signed [DLT_W-1:0] e0c, e1c;
    always_comb
    begin
        case (c_reg)
            2'd0:    begin e0c = t_reg.e0x; e1c = t_reg.e1x; end
            2'd1:    begin e0c = t_reg.e0y; e1c = t_reg.e1y; end
            default: begin e0c = t_reg.e0z; e1c = t_reg.e1z; end
        endcase
    end

    logic signed [NUM_W-1:0] num, det;
    assign num = NUM_W'(pa_reg) - NUM_W'(pb_reg);
    assign det = NUM_W'(da_reg) - NUM_W'(db_reg);

    logic [NUM_W:0] rsh, rsub;
    assign rsh  = {rem_reg[NUM_W-1:0], dvd_reg[DVD_W-1]};
    assign rsub = rsh - {1'b0, dmag_reg};

    logic [QUO_W-1:0]      qmag;
    assign qmag = quo_reg[QUO_W] || (quo_reg[QUO_W-1:0] > Q_CLAMP) ? Q_CLAMP : quo_reg[QUO_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_CLR;
            clr_reg   <= '0;
            out_valid <= 1'b0;
            k_reg     <= 2'd0;
            c_reg     <= 2'd0;
        end
        else
        begin
            case (st_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (ADDR_W+1)'(VERTEX_COUNT - 1))
                        st_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        t_reg  <= q_data;
                        c_reg  <= 2'd0;
                        k_reg  <= 2'd0;
                        da_reg <= PRD_W'(q_data.du0 * q_data.dv1);
                        db_reg <= PRD_W'(q_data.du1 * q_data.dv0);
                        st_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    // numerator products for this component
                    degen_reg <= (det == '0);
                    dneg_reg  <= det[NUM_W-1];
                    dmag_reg  <= det[NUM_W-1] ? -det : det;
                    pa_reg <= PRD_W'(t_reg.dv1 * e0c);
                    pb_reg <= PRD_W'(t_reg.dv0 * e1c);
                    st_reg <= (det == '0) ? S_RD : S_SUB;
                end
                S_SUB:
                begin
                    qneg_reg <= num[NUM_W-1] ^ dneg_reg;
                    dvd_reg  <= {(num[NUM_W-1] ? -num : num), 15'd0} << 1;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    bit_reg  <= 7'(DVD_W - 1);
                    st_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    // restoring division, one bit per cycle
                    dvd_reg <= dvd_reg << 1;
                    if (!rsub[NUM_W])
                    begin
                        rem_reg <= rsub;
                        quo_reg <= {quo_reg[QUO_W-1:0], 1'b1} | {quo_reg[QUO_W], {QUO_W{1'b0}}};
                    end
                    else
                    begin
                        rem_reg <= rsh;
                        quo_reg <= {quo_reg[QUO_W-1:0], 1'b0} | {quo_reg[QUO_W], {QUO_W{1'b0}}};
                    end
                    if (bit_reg == 7'd0)
                        st_reg <= S_WAIT;
                    else
                        bit_reg <= bit_reg - 7'd1;
                end
                S_WAIT:
                begin
                    dir_reg[c_reg] <= qneg_reg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
                    if (c_reg == 2'd2)
                    begin
                        c_reg  <= 2'd0;
                        st_reg <= S_RD;
                    end
                    else
                    begin
                        c_reg  <= c_reg + 2'd1;
                        st_reg <= S_MUL;
                    end
                end
                S_RD:
                begin
                    // read slot issued; data lands in rd_reg
                    st_reg <= (degen_reg || !inr) ? ((k_reg == 2'd2) ? S_ORD : S_RD) : S_WR;
                    if (degen_reg || !inr)
                    begin
                        if (k_reg == 2'd2)
                            k_reg <= 2'd0;
                        else
                            k_reg <= k_reg + 2'd1;
                    end
                end
                S_WR:
                begin
                    if (k_reg == 2'd2)
                    begin
                        k_reg  <= 2'd0;
                        st_reg <= S_ORD;
                    end
                    else
                    begin
                        k_reg  <= k_reg + 2'd1;
                        st_reg <= S_RD;
                    end
                end
                S_ORD:
                    st_reg <= S_OWT;
                S_OWT:
                begin
                    out_valid        <= 1'b1;
                    out_vertex       <= cur_idx;
                    sum_x            <= inr ? rd_reg[3*SUM_W-1:2*SUM_W] : '0;
                    sum_y            <= inr ? rd_reg[2*SUM_W-1:SUM_W] : '0;
                    sum_z            <= inr ? rd_reg[SUM_W-1:0] : '0;
                    degenerate       <= degen_reg;
                    last_of_triangle <= (k_reg == 2'd2);
                    st_reg           <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        if (k_reg == 2'd2)
                        begin
                            k_reg  <= 2'd0;
                            st_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg  <= k_reg + 2'd1;
                            st_reg <= S_ORD;
                        end
                    end
                end
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end

    // store port: clear sweep, read, and read-modify-write
    always_ff @(posedge clk)
    begin
        if (st_reg == S_CLR)
            mem[clr_reg[ADDR_W-1:0]] <= '0;
        else if (st_reg == S_WR)
            mem[addr] <= {sat_add(rd_reg[3*SUM_W-1:2*SUM_W], dir_reg[0]),
                          sat_add(rd_reg[2*SUM_W-1:SUM_W], dir_reg[1]),
                          sat_add(rd_reg[SUM_W-1:0], dir_reg[2])};
        rd_reg <= mem[addr];
    end

endmodule

### design/triangle_tangent_accumulator.sv
// Triangle tangent accumulator.
// Input channel (in_valid/in_ready) takes one triangle corner per request:
// vertex index, position and texture coordinate in signed Q16.16.
// The first two corners of a triangle are held; the third completes it and
// is passed through a two-entry queue to the back end, which forms the UV
// determinant, divides each tangent component with a one-bit-per-cycle
// restoring divider, and read-modify-writes the three sums of each corner
// in the 4096-entry store.
// Output channel (out_valid/out_ready) then delivers three results, one per
// corner in order, the last flagged with last_of_triangle. A zero
// determinant skips the divide and the update, and flags degenerate.
// A triangle occupies the back end until its third result is taken; no
// new triangle is accepted before then, so the serial divider sets
// throughput.
// After reset all store entries are cleared in a sweep; the front still
// holds up to two corners plus two queued triangles during it. When the
// receiver stalls the result register holds and the back end waits, and
// the front stalls once the queue is full.
module triangle_tangent_accumulator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [tta_pkg::IDX_W-1:0]        vertex_index,
    input  logic signed [tta_pkg::CRD_W-1:0] pos_x,
    input  logic signed [tta_pkg::CRD_W-1:0] pos_y,
    input  logic signed [tta_pkg::CRD_W-1:0] pos_z,
    input  logic signed [tta_pkg::CRD_W-1:0] tex_u,
    input  logic signed [tta_pkg::CRD_W-1:0] tex_v,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tta_pkg::IDX_W-1:0]        out_vertex,
    output logic signed [tta_pkg::SUM_W-1:0] sum_x,
    output logic signed [tta_pkg::SUM_W-1:0] sum_y,
    output logic signed [tta_pkg::SUM_W-1:0] sum_z,
    output logic                             degenerate,
    output logic                             last_of_triangle
);
    import tta_pkg::*;

    tri_t f_data, b_data;
    logic f_valid, f_ready, b_valid, b_ready;

    tta_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .vertex_index(vertex_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .tex_u(tex_u), .tex_v(tex_v),
        .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
    );

    tta_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
    );

    tta_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_vertex(out_vertex), .sum_x(sum_x), .sum_y(sum_y), .sum_z(sum_z),
        .degenerate(degenerate), .last_of_triangle(last_of_triangle)
    );

endmodule
